// ===== rtl/csc_pkg.sv =====
// types and constants for the counter sequence checker
// no dependencies; used by counter_sequence_checker
`default_nettype none

package csc_pkg;

  // check mode register codes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ALL    = 2'd1;
  localparam logic [1:0] MODE_BUFFER = 2'd2;

  // request kinds
  localparam logic KIND_DATA     = 1'b0;
  localparam logic KIND_LOG_READ = 1'b1;

  // fixed field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFFSET_W = 19;
  localparam int unsigned WOFF_W   = 17;
  localparam int unsigned CHECKS_W = 48;
  localparam int unsigned LOGCNT_W = 5;
  localparam int unsigned INDEX_W  = 4;

  // input request
  typedef struct packed {
    logic                kind;
    logic [WORD_W-1:0]   data_word;
    logic                start_of_transfer;
    logic [INDEX_W-1:0]  log_index;
  } csc_in_t;

  // result
  typedef struct packed {
    logic                checked;
    logic                mismatch;
    logic [WORD_W-1:0]   expected_value;
    logic [WORD_W-1:0]   actual_value;
    logic [WORD_W-1:0]   transfer_number;
    logic [OFFSET_W-1:0] byte_offset;
    logic [WORD_W-1:0]   error_count;
    logic [CHECKS_W-1:0] checked_count;
    logic [LOGCNT_W-1:0] logged_count;
    logic                log_valid;
  } csc_out_t;

  // one error log entry
  typedef struct packed {
    logic [WORD_W-1:0]   xfer;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]   expected;
    logic [WORD_W-1:0]   actual;
  } csc_log_t;

endpackage

`default_nettype wire

// ===== rtl/counter_sequence_checker.sv =====
// counter sequence checker: checks a word stream for an incrementing counter
// depends on csc_pkg
// pipeline: a result is registered in stage A on accept, then in output stage B
// throughput: one request per cycle while in_stall_o is low; the state update,
//   the log memory write and the log read data all register on accept
// reset: all counters, the check mode and the pipeline clear at once; the
//   error log memory is not cleared, entries at or above the fill count read 0
`default_nettype none

module counter_sequence_checker
  import csc_pkg::*;
#(
  parameter int unsigned DMA_BUFFER_BYTES = 32768,
  parameter int unsigned TRANSFER_BYTES   = 524288,
  parameter int unsigned LOG_DEPTH        = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire csc_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output csc_out_t      out_data_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [1:0] cfg_data_i
);

  localparam int unsigned OFF_LIM = ((TRANSFER_BYTES / 4) > 131072) ? 131072
                                                                    : (TRANSFER_BYTES / 4);
  localparam int unsigned BUF_W   = $clog2(DMA_BUFFER_BYTES + 4);
  localparam int unsigned FILL_W  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned AW      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CMP_W   = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;

  // configuration
  logic [1:0] mode_q;

  // checker state
  logic [WORD_W-1:0]   exp_q, exp_d;
  logic                seeded_q, seeded_d;
  logic [WORD_W-1:0]   err_q, err_d;
  logic [CHECKS_W-1:0] chk_q, chk_d;
  logic [WORD_W-1:0]   xfer_q, xfer_d;
  logic [WOFF_W-1:0]   woff_q, woff_d;
  logic [BUF_W-1:0]    buf_q, buf_d;
  logic [FILL_W-1:0]   fill_q, fill_d;

  // error log memory
  csc_log_t log_mem [LOG_DEPTH];
  csc_log_t rdata_q;
  logic     log_we;
  csc_log_t log_wdata;

  // pipeline
  logic     a_valid_q, b_valid_q;
  logic     a_hit_q, a_hit_d;
  csc_out_t a_res_q, a_res_d;
  csc_out_t b_res_q, b_res_d;
  logic     a_move, accept;

  // per-word datapath
  logic [WOFF_W-1:0]   cur;
  logic [BUF_W-1:0]    buf_cur, buf_inc;
  logic [WOFF_W:0]     cur_inc;
  logic [OFFSET_W-1:0] byte_off;
  logic [WORD_W-1:0]   xfer_cur, exp_eff;
  logic                do_check, miss, log_room, rd_hit;

  // handshake
  assign a_move      = a_valid_q && (!b_valid_q || !out_stall_i);
  assign in_stall_o  = a_valid_q && !a_move;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_res_q;

  // offset and transfer tracking for the current word
  always_comb begin
    cur      = in_data_i.start_of_transfer ? '0 : woff_q;
    buf_cur  = in_data_i.start_of_transfer ? '0 : buf_q;
    xfer_cur = in_data_i.start_of_transfer ? xfer_q + 1'b1 : xfer_q;
    byte_off = {cur, 2'b00};
    cur_inc  = {1'b0, cur} + 1'b1;
    buf_inc  = buf_cur + BUF_W'(4);
    if (buf_inc >= BUF_W'(DMA_BUFFER_BYTES)) begin
      buf_inc = buf_inc - BUF_W'(DMA_BUFFER_BYTES);
    end
  end

  // compare and counter update
  always_comb begin
    do_check = (mode_q == MODE_ALL) || ((mode_q == MODE_BUFFER) && (buf_cur == '0));
    exp_eff  = seeded_q ? exp_q : in_data_i.data_word;
    miss     = do_check && (in_data_i.data_word != exp_eff);
    log_room = fill_q < FILL_W'(LOG_DEPTH);
    rd_hit   = CMP_W'(in_data_i.log_index) < CMP_W'(fill_q);

    exp_d    = exp_q;
    seeded_d = seeded_q;
    err_d    = err_q;
    chk_d    = chk_q;
    xfer_d   = xfer_q;
    woff_d   = woff_q;
    buf_d    = buf_q;
    fill_d   = fill_q;
    log_we   = 1'b0;

    log_wdata.xfer     = xfer_cur;
    log_wdata.offset   = byte_off;
    log_wdata.expected = exp_eff;
    log_wdata.actual   = in_data_i.data_word;

    if (in_data_i.kind == KIND_DATA) begin
      xfer_d = xfer_cur;
      if (cur_inc >= (WOFF_W + 1)'(OFF_LIM)) begin
        woff_d = '0;
        buf_d  = '0;
      end else begin
        woff_d = cur_inc[WOFF_W-1:0];
        buf_d  = buf_inc;
      end
      if (do_check) begin
        seeded_d = 1'b1;
        exp_d    = in_data_i.data_word + 1'b1;
        if (chk_q != '1) begin
          chk_d = chk_q + 1'b1;
        end
        if (miss) begin
          if (err_q != '1) begin
            err_d = err_q + 1'b1;
          end
          if (log_room) begin
            log_we = 1'b1;
            fill_d = fill_q + 1'b1;
          end
        end
      end
    end

    // result as known at accept time; log fields fill in on the way to the output register
    a_res_d.checked         = 1'b0;
    a_res_d.mismatch        = 1'b0;
    a_res_d.expected_value  = '0;
    a_res_d.actual_value    = '0;
    a_res_d.transfer_number = '0;
    a_res_d.byte_offset     = '0;
    a_res_d.error_count     = err_d;
    a_res_d.checked_count   = chk_d;
    a_res_d.logged_count    = LOGCNT_W'(fill_d);
    a_res_d.log_valid       = 1'b0;
    a_hit_d                 = 1'b0;
    if (in_data_i.kind == KIND_DATA) begin
      a_res_d.checked         = do_check;
      a_res_d.mismatch        = miss;
      a_res_d.expected_value  = do_check ? exp_eff : exp_q;
      a_res_d.actual_value    = in_data_i.data_word;
      a_res_d.transfer_number = xfer_cur;
      a_res_d.byte_offset     = byte_off;
    end else begin
      a_res_d.log_valid = rd_hit;
      a_hit_d           = rd_hit;
    end
  end

  // merge log read data on the way to the output register
  always_comb begin
    b_res_d = a_res_q;
    if (a_hit_q) begin
      b_res_d.expected_value  = rdata_q.expected;
      b_res_d.actual_value    = rdata_q.actual;
      b_res_d.transfer_number = rdata_q.xfer;
      b_res_d.byte_offset     = rdata_q.offset;
    end
  end

  // log memory: write on logged mismatch, registered read on log request
  always_ff @(posedge clk_i) begin
    if (accept && log_we) begin
      log_mem[AW'(fill_q)] <= log_wdata;
    end
    if (accept && (in_data_i.kind == KIND_LOG_READ)) begin
      rdata_q <= log_mem[AW'(in_data_i.log_index)];
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      exp_q     <= '0;
      seeded_q  <= 1'b0;
      err_q     <= '0;
      chk_q     <= '0;
      xfer_q    <= '0;
      woff_q    <= '0;
      buf_q     <= '0;
      fill_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (accept) begin
        exp_q    <= exp_d;
        seeded_q <= seeded_d;
        err_q    <= err_d;
        chk_q    <= chk_d;
        xfer_q   <= xfer_d;
        woff_q   <= woff_d;
        buf_q    <= buf_d;
        fill_q   <= fill_d;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_res_q <= a_res_d;
      a_hit_q <= a_hit_d;
    end
    if (a_move) begin
      b_res_q <= b_res_d;
    end
  end

endmodule

`default_nettype wire
